/* rtl/mfd_pkg.sv */
// Shared types and constants for the multilevel feedback dispatcher.
package mfd_pkg;

    localparam int NUM_LEVELS = 4;

    typedef logic [1:0] level_t;

    localparam level_t LEVEL_RT   = 2'd0;
    localparam level_t LAST_LEVEL = 2'd3;

    typedef enum logic
    {
        OP_ARRIVAL = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

endpackage

/* rtl/mfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mfd_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/multilevel_feedback_dispatcher_top.sv */
// Multilevel feedback dispatcher: four FIFO levels of processes in one RAM.
//
// Input channel (in_valid / in_stall) takes one beat per item: an arrival
// (operation = 0) queues process_id with burst_ticks at level priority_req,
// a tick (operation = 1) runs one time slice of the highest non-empty level.
// Output channel (out_valid / out_stall) returns exactly one beat per item.
// Arrival: result is registered at the accept edge.
// Tick with a waiting process: the head is read from the RAM in the accept
// cycle, then in ST_READ it is modified and, unless finished, written back
// (at most one RAM access per cycle). Idle tick: registered like an arrival.
// The output register holds one result; a new item is taken while that
// result is being taken in the same cycle. While out_stall holds a result,
// in_stall is raised and a tick in progress waits with its read data held.
// Reset clears all level pointers and counts, sets the time counter to one
// and empties the output register; the RAM needs no clearing since every
// read is guarded by the level counts.
module multilevel_feedback_dispatcher_top
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 8,
    parameter int TICK_BITS   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  process_id,
    input  logic [1:0]  priority_req,
    input  logic [15:0] burst_ticks,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        served,
    output logic [7:0]  served_id,
    output logic [1:0]  served_level,
    output logic        finished,
    output logic [31:0] finish_time,
    output logic        dropped
);

    import mfd_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_D   = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(RAM_D);
    localparam int ENTRY_W = ID_BITS + TICK_BITS;

    state_t               state_reg, state_next;
    level_t               lvl_reg, lvl_next;
    logic [PTR_W-1:0]     head_reg [NUM_LEVELS];
    logic [PTR_W-1:0]     head_next [NUM_LEVELS];
    logic [PTR_W-1:0]     tail_reg [NUM_LEVELS];
    logic [PTR_W-1:0]     tail_next [NUM_LEVELS];
    logic [CNT_W-1:0]     count_reg [NUM_LEVELS];
    logic [CNT_W-1:0]     count_next [NUM_LEVELS];
    logic [CNT_W-1:0]     live_reg, live_next;
    logic [31:0]          time_reg, time_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 served_reg, served_next;
    logic [7:0]           served_id_reg, served_id_next;
    level_t               served_level_reg, served_level_next;
    logic                 finished_reg, finished_next;
    logic [31:0]          finish_time_reg, finish_time_next;
    logic                 dropped_reg, dropped_next;

    logic [NUM_LEVELS-1:0] nonempty;
    logic                 any_ready;
    level_t               found;
    level_t               next_lvl;
    level_t               head_idx, tail_idx;
    logic [PTR_W-1:0]     head_sel, tail_sel;
    logic                 out_free;
    logic                 in_accept;
    logic                 live_full;

    logic                 push_en, pop_en;
    level_t               push_lvl, pop_lvl;
    logic                 rd_en, wr_en;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic [ENTRY_W-1:0]   wr_data, rd_data;
    logic [TICK_BITS-1:0] entry_ticks;
    logic [ID_BITS-1:0]   entry_id;
    logic                 entry_done;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ram_addr(input level_t lvl,
                                                   input logic [PTR_W-1:0] pos);
        return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
    endfunction

    mfd_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_D)
    )
    u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
        end
    end

    always_comb
    begin
        any_ready = |nonempty;
        if (nonempty[0])
        begin
            found = LEVEL_RT;
        end
        else if (nonempty[1])
        begin
            found = level_t'(1);
        end
        else if (nonempty[2])
        begin
            found = level_t'(2);
        end
        else
        begin
            found = LAST_LEVEL;
        end
    end

    assign next_lvl    = (lvl_reg == LAST_LEVEL) ? LAST_LEVEL : lvl_reg + 1'b1;
    assign head_idx    = (state_reg == ST_IDLE) ? found : lvl_reg;
    assign tail_idx    = (state_reg == ST_IDLE) ? level_t'(priority_req) : next_lvl;
    assign head_sel    = head_reg[head_idx];
    assign tail_sel    = tail_reg[tail_idx];

    assign out_free    = !out_valid_reg || !out_stall;
    assign in_stall    = !((state_reg == ST_IDLE) && out_free);
    assign in_accept   = in_valid && !in_stall;
    assign live_full   = (live_reg == CNT_W'(QUEUE_DEPTH));

    assign entry_ticks = rd_data[TICK_BITS-1:0];
    assign entry_id    = rd_data[ENTRY_W-1:TICK_BITS];
    assign entry_done  = (entry_ticks <= TICK_BITS'(1));

    always_comb
    begin
        state_next        = state_reg;
        lvl_next          = lvl_reg;
        live_next         = live_reg;
        time_next         = time_reg;
        push_en           = 1'b0;
        push_lvl          = tail_idx;
        pop_en            = 1'b0;
        pop_lvl           = lvl_reg;
        rd_en             = 1'b0;
        rd_addr           = ram_addr(head_idx, head_sel);
        wr_en             = 1'b0;
        wr_addr           = ram_addr(tail_idx, tail_sel);
        wr_data           = {ID_BITS'(process_id), TICK_BITS'(burst_ticks)};

        out_valid_next    = out_valid_reg && out_stall;
        served_next       = served_reg;
        served_id_next    = served_id_reg;
        served_level_next = served_level_reg;
        finished_next     = finished_reg;
        finish_time_next  = finish_time_reg;
        dropped_next      = dropped_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (op_t'(operation) == OP_ARRIVAL)
                    begin
                        out_valid_next    = 1'b1;
                        served_next       = 1'b0;
                        served_id_next    = '0;
                        served_level_next = LEVEL_RT;
                        finished_next     = 1'b0;
                        finish_time_next  = '0;
                        dropped_next      = live_full;
                        if (!live_full)
                        begin
                            push_en   = 1'b1;
                            wr_en     = 1'b1;
                            live_next = live_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        time_next = time_reg + 1'b1;
                        if (any_ready)
                        begin
                            rd_en      = 1'b1;
                            lvl_next   = found;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            out_valid_next    = 1'b1;
                            served_next       = 1'b0;
                            served_id_next    = '0;
                            served_level_next = LEVEL_RT;
                            finished_next     = 1'b0;
                            finish_time_next  = '0;
                            dropped_next      = 1'b0;
                        end
                    end
                end
            end

            ST_READ:
            begin
                // read data stays put until the output register frees up
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    served_next       = 1'b1;
                    served_id_next    = 8'(entry_id);
                    served_level_next = lvl_reg;
                    finished_next     = entry_done;
                    finish_time_next  = entry_done ? time_reg - 1'b1 : '0;
                    dropped_next      = 1'b0;
                    wr_data           = {entry_id, entry_ticks - 1'b1};
                    state_next        = ST_IDLE;
                    if (entry_done && live_reg != '0)
                    begin
                        live_next = live_reg - 1'b1;
                    end
                    if (lvl_reg == LEVEL_RT)
                    begin
                        // real-time head is updated in place
                        if (entry_done)
                        begin
                            pop_en = 1'b1;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = ram_addr(LEVEL_RT, head_sel);
                        end
                    end
                    else
                    begin
                        pop_en = 1'b1;
                        if (!entry_done)
                        begin
                            push_en = 1'b1;
                            wr_en   = 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
            if (push_en && push_lvl == level_t'(i))
            begin
                tail_next[i] = ptr_inc(tail_reg[i]);
            end
            if (pop_en && pop_lvl == level_t'(i))
            begin
                head_next[i] = ptr_inc(head_reg[i]);
            end
            case ({push_en && push_lvl == level_t'(i), pop_en && pop_lvl == level_t'(i)})
                2'b10:   count_next[i] = count_reg[i] + 1'b1;
                2'b01:   count_next[i] = count_reg[i] - 1'b1;
                default: count_next[i] = count_reg[i];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= LEVEL_RT;
            live_reg      <= '0;
            time_reg      <= 32'd1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            live_reg      <= live_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        served_reg       <= served_next;
        served_id_reg    <= served_id_next;
        served_level_reg <= served_level_next;
        finished_reg     <= finished_next;
        finish_time_reg  <= finish_time_next;
        dropped_reg      <= dropped_next;
    end

    assign out_valid    = out_valid_reg;
    assign served       = served_reg;
    assign served_id    = served_id_reg;
    assign served_level = served_level_reg;
    assign finished     = finished_reg;
    assign finish_time  = finish_time_reg;
    assign dropped      = dropped_reg;

endmodule
